@@ design/src_pkg.sv @@
// ----------------------------------------------------------------------------
// src_pkg
// shared widths, opcodes and reset values of the sorted range classifier
// ----------------------------------------------------------------------------
`default_nettype none

package src_pkg;

  // field widths
  localparam int ValueW = 16;
  localparam int ColorW = 32;
  localparam int ScaleW = 16;
  localparam int CountW = 4;

  // table depth default
  localparam int MaxRangesDefault = 8;

  // max_limit after reset
  localparam logic signed [ValueW-1:0] MaxLimitReset = 16'sd255;

  // opcodes
  localparam logic OpAdd    = 1'b0;
  localparam logic OpLookup = 1'b1;

  // divider steps, one quotient bit each
  localparam int DivSteps = ScaleW;
  localparam int StepW    = $clog2(DivSteps);
  localparam logic [StepW-1:0] DivLast = StepW'(DivSteps - 1);

endpackage : src_pkg

`default_nettype wire

@@ design/sorted_range_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_range_classifier_unit
// sorted table of ranges with insert and lookup, scaled level by serial divide
// ----------------------------------------------------------------------------
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// command   | in        | start, busy (accept=start  | op_i, value_i, color_i, scale_i
//           |           | while busy is low)         |
// result    | out       | done_o strobe, one cycle   | ok_o, count_o, color_out_o,
//           |           |                            | level_o
// config    | in        | cfg_valid_i / cfg_ready_o  | cfg_data_i (max_limit)
//
// an add reads the entry below the insert slot and moves it up while its lower
// limit is above the new value, then writes the new entry (a full table stores
// nothing); a lookup reads entries in order until the first lower limit above
// the value or the end of the table, reads the match, forms span, offset and
// product, then runs the serial divide and raises the strobe
// the sequence follows from the table memory, whose registered read is checked
// in a separate state, and the restoring divider, one quotient bit per cycle
// reset clears the entry count, the sequencer and max_limit (back to 255)
// results cannot be stalled; busy stays high until the strobe cycle
//
`default_nettype none

module sorted_range_classifier_unit
  import src_pkg::*;
#(
  parameter int MAX_RANGES = MaxRangesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // command transaction
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     op_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic [ColorW-1:0]        color_i,
  input  wire logic [ScaleW-1:0]        scale_i,
  // result transaction
  output logic                          done_o,
  output logic                          ok_o,
  output logic [CountW-1:0]             count_o,
  output logic [ColorW-1:0]             color_out_o,
  output logic [ScaleW-1:0]             level_o,
  // configuration transaction
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic signed [ValueW-1:0] cfg_data_i
);

  // address width of the table, entry count width (holds MAX_RANGES itself)
  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] FullCnt = CW'(MAX_RANGES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,   // check full, read entry below the insert slot
    S_INS_CHK,  // move that entry up or drop the new one in
    S_LK_RD,    // read next entry of the scan
    S_LK_CHK,   // stop at the first lower limit above the value
    S_LK_SEL,   // read the matching entry
    S_LK_SPAN,  // span and offset of the match
    S_MUL,      // scale * offset into the divider
    S_DIV       // one quotient bit per cycle
  } state_e;

  state_e state_q;

  // table memory, entries at and above the count may be read but their data is never used
  logic signed [ValueW-1:0] lo_mem  [MAX_RANGES];
  logic [ColorW-1:0]        col_mem [MAX_RANGES];

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [ValueW-1:0] mem_wlo;
  logic [ColorW-1:0]        mem_wcol;
  logic [AW-1:0]            mem_raddr;
  logic signed [ValueW-1:0] rd_lo_q;
  logic [ColorW-1:0]        rd_col_q;

  // control and datapath registers
  logic [CW-1:0]            cnt_q;
  logic [CW-1:0]            idx_q;
  logic signed [ValueW-1:0] max_q;
  logic signed [ValueW-1:0] val_q;
  logic [ColorW-1:0]        col_q;
  logic [ScaleW-1:0]        scale_q;
  logic signed [ValueW-1:0] hi_q;
  logic [ScaleW-1:0]        span_q;
  logic [ScaleW-1:0]        off_q;
  logic [ScaleW-1:0]        rem_q;
  logic [ScaleW-1:0]        low_q;
  logic [StepW-1:0]         step_q;

  // registered result
  logic                     done_q;
  logic                     ok_q;
  logic [CountW-1:0]        count_q;
  logic [ColorW-1:0]        color_res_q;
  logic [ScaleW-1:0]        level_q;

  logic [CW-1:0]            idx_m1;
  logic [CW-1:0]            cnt_p1;
  logic                     move_up;
  logic signed [ValueW:0]   span_w;
  logic signed [ValueW:0]   off_w;
  logic [ScaleW:0]          rem_sh;
  logic                     div_ge;
  logic [ScaleW:0]          rem_sub;
  logic [2*ScaleW-1:0]      prod;

  assign idx_m1  = idx_q - CW'(1);
  assign cnt_p1  = cnt_q + CW'(1);
  assign move_up = (rd_lo_q > val_q);

  // span and offset of the matched range, never negative here
  assign span_w = {hi_q[ValueW-1], hi_q} - {rd_lo_q[ValueW-1], rd_lo_q};
  assign off_w  = {val_q[ValueW-1], val_q} - {rd_lo_q[ValueW-1], rd_lo_q};

  assign prod = scale_q * off_q;

  // shared compare/subtract of the restoring divider
  assign rem_sh  = {rem_q, low_q[ScaleW-1]};
  assign div_ge  = (rem_sh >= {1'b0, span_q});
  assign rem_sub = rem_sh - {1'b0, span_q};

  // memory addressing follows the sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wlo   = val_q;
    mem_wcol  = col_q;
    mem_raddr = '0;
    case (state_q)
      S_INS_RD: begin
        mem_raddr = idx_m1[AW-1:0];
        if (cnt_q != FullCnt && idx_q == '0) begin
          mem_we = 1'b1;
        end
      end
      S_INS_CHK: begin
        mem_we = 1'b1;
        if (move_up) begin
          mem_wlo  = rd_lo_q;
          mem_wcol = rd_col_q;
        end
      end
      S_LK_RD: begin
        mem_raddr = idx_q[AW-1:0];
      end
      S_LK_SEL: begin
        mem_raddr = idx_m1[AW-1:0];
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lo_mem[mem_waddr]  <= mem_wlo;
      col_mem[mem_waddr] <= mem_wcol;
    end
    rd_lo_q  <= lo_mem[mem_raddr];
    rd_col_q <= col_mem[mem_raddr];
  end

  // max_limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      count_q     <= '0;
      color_res_q <= '0;
      level_q     <= '0;
      step_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            val_q   <= value_i;
            col_q   <= color_i;
            scale_q <= scale_i;
            if (op_i == OpAdd) begin
              idx_q   <= cnt_q;
              state_q <= S_INS_RD;
            end else begin
              idx_q   <= '0;
              state_q <= S_LK_RD;
            end
          end
        end

        S_INS_RD: begin
          if (cnt_q == FullCnt) begin
            // table full, nothing stored
            done_q      <= 1'b1;
            ok_q        <= 1'b0;
            count_q     <= '0;
            color_res_q <= '0;
            level_q     <= '0;
            state_q     <= S_IDLE;
          end else if (idx_q == '0) begin
            cnt_q       <= cnt_p1;
            done_q      <= 1'b1;
            ok_q        <= 1'b1;
            count_q     <= CountW'(cnt_p1);
            color_res_q <= '0;
            level_q     <= '0;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_INS_CHK;
          end
        end

        S_INS_CHK: begin
          if (move_up) begin
            idx_q   <= idx_m1;
            state_q <= S_INS_RD;
          end else begin
            cnt_q       <= cnt_p1;
            done_q      <= 1'b1;
            ok_q        <= 1'b1;
            count_q     <= CountW'(cnt_p1);
            color_res_q <= '0;
            level_q     <= '0;
            state_q     <= S_IDLE;
          end
        end

        S_LK_RD: begin
          if (idx_q == cnt_q) begin
            // past the last entry, top end is max_limit
            if (idx_q == '0 || val_q > max_q) begin
              done_q      <= 1'b1;
              ok_q        <= 1'b0;
              count_q     <= CountW'(cnt_q);
              color_res_q <= '0;
              level_q     <= '0;
              state_q     <= S_IDLE;
            end else begin
              hi_q    <= max_q;
              state_q <= S_LK_SEL;
            end
          end else begin
            state_q <= S_LK_CHK;
          end
        end

        S_LK_CHK: begin
          if (move_up) begin
            if (idx_q == '0) begin
              // value below the first range
              done_q      <= 1'b1;
              ok_q        <= 1'b0;
              count_q     <= CountW'(cnt_q);
              color_res_q <= '0;
              level_q     <= '0;
              state_q     <= S_IDLE;
            end else begin
              hi_q    <= rd_lo_q - ValueW'(1);
              state_q <= S_LK_SEL;
            end
          end else begin
            idx_q   <= cnt_p1 == '0 ? idx_q : idx_q + CW'(1);
            state_q <= S_LK_RD;
          end
        end

        S_LK_SEL: begin
          state_q <= S_LK_SPAN;
        end

        S_LK_SPAN: begin
          span_q      <= span_w[ScaleW-1:0];
          off_q       <= off_w[ScaleW-1:0];
          color_res_q <= rd_col_q;
          if (span_w == '0) begin
            // zero span, level stays 0
            done_q  <= 1'b1;
            ok_q    <= 1'b1;
            count_q <= CountW'(cnt_q);
            level_q <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL;
          end
        end

        S_MUL: begin
          rem_q   <= prod[2*ScaleW-1:ScaleW];
          low_q   <= prod[ScaleW-1:0];
          step_q  <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          rem_q  <= div_ge ? rem_sub[ScaleW-1:0] : rem_sh[ScaleW-1:0];
          low_q  <= {low_q[ScaleW-2:0], div_ge};
          step_q <= step_q + StepW'(1);
          if (step_q == DivLast) begin
            done_q  <= 1'b1;
            ok_q    <= 1'b1;
            count_q <= CountW'(cnt_q);
            level_q <= {low_q[ScaleW-2:0], div_ge};
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign count_o     = count_q;
  assign color_out_o = color_res_q;
  assign level_o     = level_q;

endmodule : sorted_range_classifier_unit

`default_nettype wire

@@ design/src_checker.sv @@
// ----------------------------------------------------------------------------
// src_checker
// port-level checks of the sorted range classifier
// ----------------------------------------------------------------------------
`default_nettype none

module src_checker
  import src_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire logic              ok_o,
  input wire logic [CountW-1:0] count_o,
  input wire logic [ColorW-1:0] color_out_o,
  input wire logic [ScaleW-1:0] level_o
);

  // an accepted command keeps the unit busy in the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // the result strobe comes with busy already low
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // one strobe per transaction, never two in a row
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held over two cycles");

  // a miss or a failed add carries no colour and no level
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> color_out_o == '0 && level_o == '0)
    else $error("miss with nonzero colour or level");

  // an idle unit without a command stays idle
  a_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !busy)
    else $error("busy raised without a command");

endmodule : src_checker

bind sorted_range_classifier_unit src_checker u_src_checker (.*);

`default_nettype wire
